// ===== rtl/rsml_pkg.sv =====
package rsml_pkg;

    // Parser phase of the record stream
    typedef enum logic [2:0] {
        PH_BANK    = 3'd0,
        PH_OFFSET  = 3'd1,
        PH_LENGTH  = 3'd2,
        PH_DATA    = 3'd3,
        PH_SPECIAL = 3'd4,
        PH_DRAIN   = 3'd5
    } phase_t;

    // Command codes of a result item
    typedef enum logic [2:0] {
        CMD_BANK    = 3'd0,
        CMD_ADDR    = 3'd1,
        CMD_DATA    = 3'd2,
        CMD_INTEN   = 3'd3,
        CMD_DONE    = 3'd4,
        CMD_BADSPEC = 3'd5,
        CMD_TRUNC   = 3'd6
    } cmd_t;

    localparam logic [7:0] INTEN_VALUE  = 8'h32;
    localparam logic [7:0] SPECIAL_IRQ  = 8'h01;
    localparam logic [7:0] BANK_MASK    = 8'h1F;

    // At most three results follow from one input byte
    localparam int unsigned MAX_RES = 3;
    localparam int unsigned CNT_W   = 2;

    typedef struct packed {
        cmd_t       command;
        logic [7:0] value;
        logic       burst_end;
    } result_t;

    typedef struct packed {
        result_t [MAX_RES-1:0] slot;
        logic [CNT_W-1:0]      count;
    } bundle_t;

    function automatic result_t make_result(cmd_t cmd, logic [7:0] val, logic bend);
        result_t r;
        r.command   = cmd;
        r.value     = val;
        r.burst_end = bend;
        return r;
    endfunction

endpackage

// ===== rtl/rsml_stream_if.sv =====
interface rsml_stream_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;
    logic       stream_last;

    modport source (output valid, output stream_byte, output stream_last, input ready);
    modport sink   (input valid, input stream_byte, input stream_last, output ready);
endinterface

// ===== rtl/rsml_result_if.sv =====
interface rsml_result_if;
    logic              valid;
    logic              ready;
    rsml_pkg::cmd_t    command;
    logic [7:0]        value;
    logic              burst_end;
    logic              run_last;

    modport source (output valid, output command, output value, output burst_end,
                    output run_last, input ready);
    modport sink   (input valid, input command, input value, input burst_end,
                    input run_last, output ready);
endinterface

// ===== rtl/rsml_parser.sv =====
module rsml_parser #(
    parameter int unsigned BURST_MAX = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         stream_byte,
    input  logic               stream_last,
    output rsml_pkg::bundle_t  bundle
);
    localparam int unsigned BC_W = $clog2(BURST_MAX + 1);

    rsml_pkg::phase_t phase_reg, phase_next;
    logic [7:0]       bank_reg, bank_next;
    logic [7:0]       addr_reg, addr_next;
    logic [7:0]       left_reg, left_next;
    logic [BC_W-1:0]  burst_reg, burst_next;

    logic [BC_W-1:0]  burst_inc;
    logic [7:0]       left_dec;
    logic [7:0]       addr_inc;
    logic [7:0]       bank_inc;
    logic             bend;

    assign burst_inc = burst_reg + BC_W'(1);
    assign left_dec  = left_reg - 8'd1;
    assign addr_inc  = addr_reg + 8'd1;
    assign bank_inc  = bank_reg + 8'd1;
    assign bend      = (burst_inc >= BC_W'(BURST_MAX)) || (left_dec == 8'd0)
                       || (addr_inc == 8'd0);

    // Next state
    always_comb
    begin
        phase_next = phase_reg;
        bank_next  = bank_reg;
        addr_next  = addr_reg;
        left_next  = left_reg;
        burst_next = burst_reg;
        unique case (phase_reg)
            rsml_pkg::PH_BANK:
            begin
                bank_next  = stream_byte;
                phase_next = stream_last ? rsml_pkg::PH_BANK : rsml_pkg::PH_OFFSET;
            end
            rsml_pkg::PH_OFFSET:
            begin
                addr_next  = stream_byte;
                phase_next = stream_last ? rsml_pkg::PH_BANK : rsml_pkg::PH_LENGTH;
            end
            rsml_pkg::PH_LENGTH:
            begin
                if (stream_last)
                begin
                    phase_next = rsml_pkg::PH_BANK;
                end
                else if (stream_byte != 8'd0)
                begin
                    left_next  = stream_byte;
                    burst_next = '0;
                    phase_next = rsml_pkg::PH_DATA;
                end
                else
                begin
                    phase_next = rsml_pkg::PH_SPECIAL;
                end
            end
            rsml_pkg::PH_SPECIAL:
            begin
                if (stream_byte == rsml_pkg::SPECIAL_IRQ || stream_last)
                    phase_next = rsml_pkg::PH_BANK;
                else
                    phase_next = rsml_pkg::PH_DRAIN;
            end
            rsml_pkg::PH_DATA:
            begin
                addr_next = addr_inc;
                left_next = left_dec;
                if (left_dec == 8'd0 || stream_last)
                begin
                    phase_next = rsml_pkg::PH_BANK;
                    left_next  = 8'd0;
                    burst_next = '0;
                end
                else if (bend)
                begin
                    if (addr_inc == 8'd0)
                        bank_next = bank_inc;
                    burst_next = '0;
                end
                else
                begin
                    burst_next = burst_inc;
                end
            end
            default:
            begin
                phase_next = stream_last ? rsml_pkg::PH_BANK : rsml_pkg::PH_DRAIN;
            end
        endcase
    end

    // Results caused by the current byte
    always_comb
    begin
        bundle = '0;
        unique case (phase_reg) inside
            rsml_pkg::PH_BANK, rsml_pkg::PH_OFFSET:
            begin
                if (stream_last)
                begin
                    bundle.slot[0] = rsml_pkg::make_result(rsml_pkg::CMD_TRUNC, 8'd0, 1'b0);
                    bundle.count   = 2'd1;
                end
            end
            rsml_pkg::PH_LENGTH:
            begin
                if (stream_last)
                begin
                    bundle.slot[0] = rsml_pkg::make_result(rsml_pkg::CMD_TRUNC, 8'd0, 1'b0);
                    bundle.count   = 2'd1;
                end
                else if (stream_byte != 8'd0)
                begin
                    bundle.slot[0] = rsml_pkg::make_result(rsml_pkg::CMD_BANK,
                                         bank_reg & rsml_pkg::BANK_MASK, 1'b0);
                    bundle.slot[1] = rsml_pkg::make_result(rsml_pkg::CMD_ADDR, addr_reg, 1'b0);
                    bundle.count   = 2'd2;
                end
            end
            rsml_pkg::PH_SPECIAL:
            begin
                if (stream_byte == rsml_pkg::SPECIAL_IRQ)
                begin
                    bundle.slot[0] = rsml_pkg::make_result(rsml_pkg::CMD_INTEN,
                                         rsml_pkg::INTEN_VALUE, 1'b0);
                    bundle.slot[1] = rsml_pkg::make_result(rsml_pkg::CMD_DONE, 8'd0, 1'b0);
                    bundle.count   = stream_last ? 2'd2 : 2'd1;
                end
                else
                begin
                    bundle.slot[0] = rsml_pkg::make_result(rsml_pkg::CMD_BADSPEC,
                                         stream_byte, 1'b0);
                    bundle.count   = 2'd1;
                end
            end
            rsml_pkg::PH_DATA:
            begin
                bundle.slot[0] = rsml_pkg::make_result(rsml_pkg::CMD_DATA, stream_byte, bend);
                bundle.count   = 2'd1;
                if (left_dec == 8'd0)
                begin
                    if (stream_last)
                    begin
                        bundle.slot[1] = rsml_pkg::make_result(rsml_pkg::CMD_DONE, 8'd0, 1'b0);
                        bundle.count   = 2'd2;
                    end
                end
                else if (stream_last)
                begin
                    bundle.slot[1] = rsml_pkg::make_result(rsml_pkg::CMD_TRUNC, 8'd0, 1'b0);
                    bundle.count   = 2'd2;
                end
                else if (bend)
                begin
                    // Reselect; the bank steps when the address wrapped
                    bundle.slot[1] = rsml_pkg::make_result(rsml_pkg::CMD_BANK,
                                         ((addr_inc == 8'd0) ? bank_inc : bank_reg)
                                         & rsml_pkg::BANK_MASK, 1'b0);
                    bundle.slot[2] = rsml_pkg::make_result(rsml_pkg::CMD_ADDR, addr_inc, 1'b0);
                    bundle.count   = 2'd3;
                end
            end
            default:
            begin
                bundle = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= rsml_pkg::PH_BANK;
            bank_reg  <= 8'd0;
            addr_reg  <= 8'd0;
            left_reg  <= 8'd0;
            burst_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            bank_reg  <= bank_next;
            addr_reg  <= addr_next;
            left_reg  <= left_next;
            burst_reg <= burst_next;
        end
    end

endmodule

// ===== rtl/rsml_emitter.sv =====
module rsml_emitter (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  rsml_pkg::bundle_t   bundle,
    output logic                take,
    rsml_result_if.source       result
);
    rsml_pkg::result_t [rsml_pkg::MAX_RES-1:0] slot_reg;
    logic [rsml_pkg::CNT_W-1:0]                count_reg;
    logic [rsml_pkg::CNT_W-1:0]                idx_reg;
    logic                                      pop;
    logic                                      final_pop;

    assign result.valid     = (count_reg != '0);
    assign result.command   = slot_reg[idx_reg].command;
    assign result.value     = slot_reg[idx_reg].value;
    assign result.burst_end = slot_reg[idx_reg].burst_end;
    assign result.run_last  = (idx_reg == count_reg - 2'd1);

    assign pop       = result.valid && result.ready;
    assign final_pop = pop && result.run_last;
    // Take a new byte once the held results are gone or the last one leaves now
    assign take      = (count_reg == '0) || final_pop;

    always_ff @(posedge clk)
    begin
        if (load)
            slot_reg <= bundle.slot;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else if (load)
        begin
            count_reg <= bundle.count;
            idx_reg   <= '0;
        end
        else if (final_pop)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else if (pop)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

endmodule

// ===== rtl/record_stream_memory_loader.sv =====
// Channel   Modport         Payload                                  Handshake
// stream    rsml_stream_if  stream_byte[7:0], stream_last            valid/ready
// result    rsml_result_if  command[2:0], value[7:0], burst_end,     valid/ready
//                           run_last
//
// Each accepted byte is parsed at once; its zero to three results sit in a result
// register from the next cycle and leave one per cycle while the result side is
// ready; data bytes in a burst flow at one per cycle, boundaries add results.
// Reset (rst_n, async, active low) returns the parser to the bank byte of a record
// with bank, address, length and burst count at zero.
// A stalled result side holds the register; stream ready drops until the last held
// result is taken, and a new byte may enter in that same cycle.
module record_stream_memory_loader #(
    parameter int unsigned BURST_MAX = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    rsml_stream_if.sink   stream,
    rsml_result_if.source result
);
    rsml_pkg::bundle_t bundle;
    logic              take;
    logic              accept;

    // A byte is taken when the result register is free or draining this cycle
    assign stream.ready = take;
    assign accept       = stream.valid && take;

    rsml_parser #(
        .BURST_MAX (BURST_MAX)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .stream_byte (stream.stream_byte),
        .stream_last (stream.stream_last),
        .bundle      (bundle)
    );

    // Hold the results of the last byte and hand them out in order
    rsml_emitter u_emitter (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (accept),
        .bundle (bundle),
        .take   (take),
        .result (result)
    );

endmodule

// ===== tb/sv/record_stream_memory_loader_tb.sv =====
module record_stream_memory_loader_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Burst length the loader is built with
    localparam int unsigned CHUNK = 16;
    // About this many random stream bytes, ignored drain bytes not included
    localparam int unsigned RANDOM_BYTES = 100;
    // Idle percentage of each side
    localparam int unsigned IDLE_PCT = 35;
    // Cycles to wait once nothing more is expected: a byte has at most
    // three results and they leave one per cycle while the result side is ready
    localparam int unsigned TAIL_CYCLES = 8;
    // Generous bound: a few hundred bytes, three results each, random stalls
    localparam int unsigned CYCLE_LIMIT = 400000;

    // One memory command as the loader hands it out
    typedef struct packed {
        rsml_pkg::cmd_t command;
        logic [7:0]     value;
        logic           burst_end;
        logic           run_last;
    } mem_cmd_t;

    logic clk;
    logic rst_n;

    rsml_stream_if stream_ch ();
    rsml_result_if result_ch ();

    record_stream_memory_loader #(
        .BURST_MAX(CHUNK)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .stream(stream_ch),
        .result(result_ch)
    );

    // Commands the loader owes us, oldest first
    mem_cmd_t expected_cmds[$];

    // Our own copy of the record parser
    rsml_pkg::phase_t ld_phase;
    logic [7:0]       ld_bank;
    logic [7:0]       ld_addr;
    logic [7:0]       ld_left;
    logic [8:0]       ld_burst;

    int unsigned error_count;
    int unsigned cycle_count;
    int unsigned sent_items;
    int unsigned bytes_accepted;
    int unsigned cmd_seen[7];
    bit          steady_flow;

    // 4 ns clock
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog: end the run once the cycle count reaches CYCLE_LIMIT
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d commands still owed", $time, expected_cmds.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // Decide whether a side idles this cycle; never during a steady stretch
    function automatic bit idle_now();
        return !steady_flow && ($urandom_range(99) < IDLE_PCT);
    endfunction

    // Result side: drop ready at random, change it only at the falling edge
    always @(negedge clk)
    begin
        result_ch.ready <= !idle_now();
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void queue_command(rsml_pkg::cmd_t cmd, logic [7:0] val, logic bend);
        mem_cmd_t c;
        c.command   = cmd;
        c.value     = val;
        c.burst_end = bend;
        c.run_last  = 1'b0;
        expected_cmds.push_back(c);
    endfunction

    // Bank select (masked) followed by start address
    function automatic void queue_target();
        queue_command(rsml_pkg::CMD_BANK, ld_bank & rsml_pkg::BANK_MASK, 1'b0);
        queue_command(rsml_pkg::CMD_ADDR, ld_addr, 1'b0);
    endfunction

    // Advance the parser by one accepted stream byte and queue what it causes
    function automatic void predict_loader(logic [7:0] b, logic last);
        int unsigned first_new;
        logic        bend;
        first_new = expected_cmds.size();
        case (ld_phase)
            rsml_pkg::PH_BANK:
            begin
                ld_bank  = b;
                ld_phase = rsml_pkg::PH_OFFSET;
                if (last)
                begin
                    queue_command(rsml_pkg::CMD_TRUNC, 8'h00, 1'b0);
                    ld_phase = rsml_pkg::PH_BANK;
                end
            end
            rsml_pkg::PH_OFFSET:
            begin
                ld_addr  = b;
                ld_phase = rsml_pkg::PH_LENGTH;
                if (last)
                begin
                    queue_command(rsml_pkg::CMD_TRUNC, 8'h00, 1'b0);
                    ld_phase = rsml_pkg::PH_BANK;
                end
            end
            rsml_pkg::PH_LENGTH:
            begin
                if (last)
                begin
                    queue_command(rsml_pkg::CMD_TRUNC, 8'h00, 1'b0);
                    ld_phase = rsml_pkg::PH_BANK;
                end
                else if (b != 8'h00)
                begin
                    ld_left  = b;
                    ld_burst = '0;
                    queue_target();
                    ld_phase = rsml_pkg::PH_DATA;
                end
                else
                begin
                    ld_phase = rsml_pkg::PH_SPECIAL;
                end
            end
            rsml_pkg::PH_SPECIAL:
            begin
                if (b == rsml_pkg::SPECIAL_IRQ)
                begin
                    queue_command(rsml_pkg::CMD_INTEN, rsml_pkg::INTEN_VALUE, 1'b0);
                    ld_phase = rsml_pkg::PH_BANK;
                    if (last)
                        queue_command(rsml_pkg::CMD_DONE, 8'h00, 1'b0);
                end
                else
                begin
                    queue_command(rsml_pkg::CMD_BADSPEC, b, 1'b0);
                    ld_phase = last ? rsml_pkg::PH_BANK : rsml_pkg::PH_DRAIN;
                end
            end
            rsml_pkg::PH_DATA:
            begin
                ld_burst = ld_burst + 1'b1;
                ld_left  = ld_left - 1'b1;
                ld_addr  = ld_addr + 1'b1;
                bend = (ld_burst >= CHUNK) || (ld_left == 8'h00) || (ld_addr == 8'h00);
                queue_command(rsml_pkg::CMD_DATA, b, bend);
                if (ld_left == 8'h00)
                begin
                    ld_phase = rsml_pkg::PH_BANK;
                    ld_burst = '0;
                    if (last)
                        queue_command(rsml_pkg::CMD_DONE, 8'h00, 1'b0);
                end
                else if (last)
                begin
                    // truncated inside the data: no reselect
                    queue_command(rsml_pkg::CMD_TRUNC, 8'h00, 1'b0);
                    ld_phase = rsml_pkg::PH_BANK;
                    ld_left  = 8'h00;
                    ld_burst = '0;
                end
                else if (bend)
                begin
                    // address wrapped to zero: move to the next bank
                    if (ld_addr == 8'h00)
                        ld_bank = ld_bank + 1'b1;
                    ld_burst = '0;
                    queue_target();
                end
            end
            default:
            begin
                // drain after a bad special byte up to the end of the stream
                ld_phase = last ? rsml_pkg::PH_BANK : rsml_pkg::PH_DRAIN;
            end
        endcase
        if (expected_cmds.size() > first_new)
            expected_cmds[expected_cmds.size() - 1].run_last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Checker
    // ------------------------------------------------------------------

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    function automatic void check_command();
        mem_cmd_t want;
        cmd_seen[result_ch.command]++;
        if (expected_cmds.size() == 0)
        begin
            error_count++;
            $display("%0t: unexpected command %0d value %02h, expected none",
                     $time, result_ch.command, result_ch.value);
            return;
        end
        want = expected_cmds.pop_front();
        check_field("command", want.command, result_ch.command);
        check_field("value", want.value, result_ch.value);
        check_field("burst_end", want.burst_end, result_ch.burst_end);
        check_field("run_last", want.run_last, result_ch.run_last);
    endfunction

    // Check the outgoing command first, then predict from the incoming byte:
    // a byte accepted at this edge cannot have a result at the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
                check_command();
            if (stream_ch.valid && stream_ch.ready)
            begin
                bytes_accepted++;
                predict_loader(stream_ch.stream_byte, stream_ch.stream_last);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Offer one byte and hold it until the loader takes it; idle first at random
    task automatic send_byte(input logic [7:0] b, input logic last, input bit counted);
        @(negedge clk);
        while (idle_now())
        begin
            stream_ch.valid <= 1'b0;
            @(negedge clk);
        end
        stream_ch.valid       <= 1'b1;
        stream_ch.stream_byte <= b;
        stream_ch.stream_last <= last;
        do
            @(posedge clk);
        while (!stream_ch.ready);
        if (counted)
            sent_items++;
    endtask

    // Full record with random data; optionally the last data byte ends the stream
    task automatic send_record(input logic [7:0] bank, input logic [7:0] offset,
                               input logic [7:0] length, input bit ends_stream);
        send_byte(bank, 1'b0, 1'b1);
        send_byte(offset, 1'b0, 1'b1);
        send_byte(length, 1'b0, 1'b1);
        for (int unsigned i = 1; i <= length; i++)
            send_byte(8'($urandom_range(255)), ends_stream && (i == length), 1'b1);
    endtask

    // Zero-length record with its special byte
    task automatic send_special(input logic [7:0] bank, input logic [7:0] offset,
                                input logic [7:0] special, input logic last);
        send_byte(bank, 1'b0, 1'b1);
        send_byte(offset, 1'b0, 1'b1);
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(special, last, 1'b1);
    endtask

    // Interrupt enable write, then bad special bytes with and without a drain
    task automatic test_specials();
        send_special(8'h00, 8'h00, rsml_pkg::SPECIAL_IRQ, 1'b1);
        send_special(8'hFF, 8'hFF, 8'hFE, 1'b0);
        // ignored until the end of the stream
        send_byte(8'hAA, 1'b0, 1'b0);
        send_byte(8'h55, 1'b1, 1'b0);
        // bad special that is itself the final byte
        send_special(8'h15, 8'h80, 8'h00, 1'b1);
    endtask

    // Stream ends in the bank, offset and length bytes
    task automatic test_truncation();
        send_byte(8'h3C, 1'b1, 1'b1);
        send_byte(8'h01, 1'b0, 1'b1);
        send_byte(8'h7F, 1'b1, 1'b1);
        send_byte(8'h02, 1'b0, 1'b1);
        send_byte(8'h40, 1'b0, 1'b1);
        send_byte(8'h05, 1'b1, 1'b1);
    endtask

    // Highest bank, address wrapping in the middle of a record
    task automatic test_bank_wrap();
        send_byte(8'hFF, 1'b0, 1'b1);
        send_byte(8'hFE, 1'b0, 1'b1);
        send_byte(8'h03, 1'b0, 1'b1);
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(8'hFF, 1'b0, 1'b1);
        send_byte(8'h5A, 1'b1, 1'b1);
    endtask

    // Mostly well-formed records with random content, plus broken streams and noise
    task automatic test_random_stream();
        int unsigned kind;
        int unsigned len;
        int unsigned stop;
        logic [7:0]  offset;
        logic [7:0]  special;
        sent_items = 0;
        while (sent_items < RANDOM_BYTES)
        begin
            // a stretch with no idling on either side
            steady_flow = (sent_items >= 20) && (sent_items < 50);
            kind   = $urandom_range(99);
            offset = ($urandom_range(99) < 30) ? 8'($urandom_range(8'hE0, 8'hFF))
                                              : 8'($urandom_range(255));
            if (kind < 55)
            begin
                len = ($urandom_range(19) == 0) ? $urandom_range(128, 255)
                                                : $urandom_range(1, 40);
                send_record(8'($urandom_range(255)), offset, 8'(len),
                            $urandom_range(99) < 30);
            end
            else if (kind < 70)
            begin
                send_special(8'($urandom_range(255)), offset, rsml_pkg::SPECIAL_IRQ,
                             1'($urandom_range(1)));
            end
            else if (kind < 80)
            begin
                do
                    special = 8'($urandom_range(255));
                while (special == rsml_pkg::SPECIAL_IRQ);
                if ($urandom_range(1))
                begin
                    send_special(8'($urandom_range(255)), offset, special, 1'b1);
                end
                else
                begin
                    send_special(8'($urandom_range(255)), offset, special, 1'b0);
                    repeat ($urandom_range(4))
                        send_byte(8'($urandom_range(255)), 1'b0, 1'b0);
                    send_byte(8'($urandom_range(255)), 1'b1, 1'b0);
                end
            end
            else if (kind < 92)
            begin
                // cut the record short at a random point
                stop = $urandom_range(3);
                send_byte(8'($urandom_range(255)), stop == 0, 1'b1);
                if (stop > 0)
                    send_byte(offset, stop == 1, 1'b1);
                if (stop == 2)
                begin
                    send_byte(8'($urandom_range(255)), 1'b1, 1'b1);
                end
                else if (stop == 3)
                begin
                    len = $urandom_range(2, 30);
                    send_byte(8'(len), 1'b0, 1'b1);
                    stop = $urandom_range(1, len - 1);
                    for (int unsigned i = 1; i <= stop; i++)
                        send_byte(8'($urandom_range(255)), i == stop, 1'b1);
                end
            end
            else
            begin
                repeat ($urandom_range(1, 3))
                    send_byte(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
            end
        end
        steady_flow = 1'b0;
    endtask

    initial
    begin
        rst_n                 = 1'b0;
        stream_ch.valid       = 1'b0;
        stream_ch.stream_byte = 8'h00;
        stream_ch.stream_last = 1'b0;
        result_ch.ready       = 1'b0;
        error_count    = 0;
        cycle_count    = 0;
        sent_items     = 0;
        bytes_accepted = 0;
        steady_flow    = 1'b0;
        foreach (cmd_seen[i])
            cmd_seen[i] = 0;
        ld_phase = rsml_pkg::PH_BANK;
        ld_bank  = 8'h00;
        ld_addr  = 8'h00;
        ld_left  = 8'h00;
        ld_burst = '0;

        // hold reset, then release it away from the rising edge
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_specials();
        test_truncation();
        test_bank_wrap();
        test_random_stream();

        @(negedge clk);
        stream_ch.valid <= 1'b0;

        // drain: wait for every owed command, then a quiet tail before the summary
        while (expected_cmds.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Loaded %0d stream bytes into %0d data writes,", bytes_accepted,
                 cmd_seen[rsml_pkg::CMD_DATA]);
        $display("%0d bank and %0d address selects, %0d irq enables, %0d done,",
                 cmd_seen[rsml_pkg::CMD_BANK], cmd_seen[rsml_pkg::CMD_ADDR],
                 cmd_seen[rsml_pkg::CMD_INTEN], cmd_seen[rsml_pkg::CMD_DONE]);
        $display("%0d bad special, %0d truncated; %0d mismatches",
                 cmd_seen[rsml_pkg::CMD_BADSPEC], cmd_seen[rsml_pkg::CMD_TRUNC],
                 error_count);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
